@@ rtl/four_level_page_table_walker_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Page table walker assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_ASSERT_SVH

// Same-cycle implication
`define FLTW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("page table walker check failed");

// Next-cycle implication
`define FLTW_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("page table walker check failed");

`endif

@@ rtl/fltw_pkg.sv @@
// ----------------------------------------------------------------------------
// Page table walker package
// Item types, command codes and the walk command passed from front to back.
// ----------------------------------------------------------------------------
package fltw_pkg;

	localparam int PHYS_ADDR_BITS = 52;
	localparam logic [51:0] ADDR_MASK = 52'((64'd1 << PHYS_ADDR_BITS) - 64'd1);

	localparam int PRESENT_BIT = 0;
	localparam int HUGE_BIT    = 7;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [1:0] SIZE_4K = 2'd0;
	localparam logic [1:0] SIZE_2M = 2'd1;
	localparam logic [1:0] SIZE_1G = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [47:0] virt_addr;
		logic [51:0] root_base;
		logic [63:0] entry_data;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [51:0] read_addr;
		logic [51:0] phys_addr;
		logic        mapped;
		logic [1:0]  size_code;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_FAULT = 2'd1,
		OP_MAP   = 2'd2
	} walk_op_t;

	// frame is the address-masked base; offset supplies the low bits under the span
	typedef struct packed {
		walk_op_t    op;
		logic [1:0]  size_code;
		logic [51:0] frame;
		logic [29:0] offset;
	} walk_cmd_t;

	function automatic logic [29:0] entry_offset(input logic [8:0] idx);
		return {18'b0, idx, 3'b000};
	endfunction

endpackage

@@ rtl/four_level_page_table_walker_unit.sv @@
// ----------------------------------------------------------------------------
// Four-level page table walker
// Walks x86-64 PML4/PDPT/PD/PT tables through an external memory that sees
// entry read requests on the result channel and answers on the input channel.
// ----------------------------------------------------------------------------
// One input transaction is taken per clock, back to back, as long as the
// two-entry command queue has room; the front-end level step writes the
// command into a queue slot when it is accepted, and the back end registers
// the result in its output register once that register is free to take it.
// The combinational level step in the front end sets the rate. A
// start with a zero root uses the kernel root register, written through
// cfg_* (always ready, write only while no walk is in flight). A start during
// a walk and read data while idle are dropped with no result. The walk ends
// with a 4 KB, 2 MB or 1 GB physical address, or with mapped low when an
// entry is absent.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fltw_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output fltw_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [51:0]         cfg_data
);
	import fltw_pkg::*;

	walk_cmd_t front_cmd;
	walk_cmd_t back_cmd;
	logic      front_valid;
	logic      front_ready;
	logic      back_valid;
	logic      back_ready;

	assign cfg_ready = 1'b1;

	fltw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	fltw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_cmd)
	);

	fltw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ rtl/fltw_front.sv @@
// ----------------------------------------------------------------------------
// Page table walker front end
// Accepts start and read-data transactions, tracks the walk level and turns
// each transaction into a walk command (or drops it).
// ----------------------------------------------------------------------------
module fltw_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  fltw_pkg::in_item_t in_data,
	input  logic               cfg_valid,
	input  logic [51:0]        cfg_data,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output fltw_pkg::walk_cmd_t cmd
);
	import fltw_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_L0   = 5'b00010,
		ST_L1   = 5'b00100,
		ST_L2   = 5'b01000,
		ST_L3   = 5'b10000
	} walk_state_t;

	walk_state_t state_q, state_d;
	logic [51:0] kroot_q;
	logic [47:0] held_virt_q;
	logic        accept;
	logic        virt_load;
	logic        huge;
	logic [51:0] root_sel;

	assign in_ready = cmd_ready;
	assign accept   = in_valid && in_ready;
	assign huge     = in_data.entry_data[HUGE_BIT];
	assign root_sel = (in_data.root_base == '0) ? kroot_q : in_data.root_base;

	always_comb begin
		state_d       = state_q;
		cmd_valid     = 1'b0;
		virt_load     = 1'b0;
		cmd.op        = OP_READ;
		cmd.size_code = SIZE_4K;
		cmd.frame     = in_data.entry_data[51:0] & ADDR_MASK;
		cmd.offset    = held_virt_q[29:0];
		if (accept) begin
			if (in_data.cmd == CMD_START) begin
				// drop a start while a walk is in flight
				if (state_q == ST_IDLE) begin
					cmd_valid  = 1'b1;
					virt_load  = 1'b1;
					cmd.frame  = root_sel & ADDR_MASK;
					cmd.offset = entry_offset(in_data.virt_addr[47:39]);
					state_d    = ST_L0;
				end
			end else if (state_q != ST_IDLE) begin
				cmd_valid = 1'b1;
				state_d   = ST_IDLE;
				priority if (!in_data.entry_data[PRESENT_BIT]) begin
					cmd.op = OP_FAULT;
				end else if (state_q == ST_L1 && huge) begin
					cmd.op        = OP_MAP;
					cmd.size_code = SIZE_1G;
				end else if (state_q == ST_L2 && huge) begin
					cmd.op        = OP_MAP;
					cmd.size_code = SIZE_2M;
				end else if (state_q == ST_L3) begin
					cmd.op = OP_MAP;
				end else begin
					// descend one level
					unique case (state_q)
						ST_L0: begin
							cmd.offset = entry_offset(held_virt_q[38:30]);
							state_d    = ST_L1;
						end
						ST_L1: begin
							cmd.offset = entry_offset(held_virt_q[29:21]);
							state_d    = ST_L2;
						end
						ST_L2: begin
							cmd.offset = entry_offset(held_virt_q[20:12]);
							state_d    = ST_L3;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kroot_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				kroot_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (virt_load) begin
			held_virt_q <= in_data.virt_addr;
		end
	end

endmodule

@@ rtl/fltw_queue.sv @@
// ----------------------------------------------------------------------------
// Page table walker command queue
// Two-entry FIFO between front and back so each side can stall on its own.
// ----------------------------------------------------------------------------
module fltw_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  fltw_pkg::walk_cmd_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output fltw_pkg::walk_cmd_t pop_data
);
	import fltw_pkg::*;

	walk_cmd_t  slots_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/fltw_back.sv @@
// ----------------------------------------------------------------------------
// Page table walker back end
// Builds the entry read address, the final physical address or a fault result
// with mapped low from a walk command and holds it in the output register.
// ----------------------------------------------------------------------------
module fltw_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  fltw_pkg::walk_cmd_t cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output fltw_pkg::out_item_t out_data
);
	import fltw_pkg::*;

	logic        out_valid_q;
	out_item_t   out_data_q;
	out_item_t   res;
	logic [51:0] span;
	logic [51:0] addr;
	logic        take;

	assign cmd_ready = !out_valid_q || out_ready;
	assign take      = cmd_valid && cmd_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		unique case (cmd.size_code)
			SIZE_2M: span = 52'h1FFFFF;
			SIZE_1G: span = 52'h3FFFFFFF;
			default: span = 52'hFFF;
		endcase
		addr = (cmd.frame & ~span) | ({22'b0, cmd.offset} & span);

		res = '0;
		unique case (cmd.op)
			OP_READ: begin
				res.kind      = KIND_READ;
				res.read_addr = addr;
			end
			OP_MAP: begin
				res.kind      = KIND_DONE;
				res.phys_addr = addr;
				res.mapped    = 1'b1;
				res.size_code = cmd.size_code;
			end
			default: begin
				res.kind = KIND_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= res;
		end
	end

endmodule

@@ rtl/fltw_checker.sv @@
// ----------------------------------------------------------------------------
// Page table walker port checker
// Watches the top-level ports for result shape, output stall behavior and cfg_ready.
// ----------------------------------------------------------------------------
`include "four_level_page_table_walker_unit_assert.svh"

module fltw_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input fltw_pkg::out_item_t out_data,
	input logic                cfg_valid,
	input logic                cfg_ready
);
	import fltw_pkg::*;

	logic is_read;
	logic is_fault;
	logic is_map;
	logic read_ok;
	logic fault_ok;
	logic map_ok;

	assign is_read  = out_valid && out_data.kind == KIND_READ;
	assign is_fault = out_valid && out_data.kind == KIND_DONE && !out_data.mapped;
	assign is_map   = out_valid && out_data.kind == KIND_DONE && out_data.mapped;

	// entry reads are 8-byte aligned and carry no translation
	assign read_ok  = !out_data.mapped && out_data.phys_addr == '0 &&
		out_data.read_addr[2:0] == 3'b000;
	assign fault_ok = out_data.phys_addr == '0 && out_data.read_addr == '0 &&
		out_data.size_code == SIZE_4K;
	assign map_ok   = out_data.read_addr == '0 && (out_data.size_code == SIZE_4K ||
		out_data.size_code == SIZE_2M || out_data.size_code == SIZE_1G);

	`FLTW_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

	`FLTW_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)

	`FLTW_ASSERT_IMP(a_read_shape, is_read, read_ok)

	`FLTW_ASSERT_IMP(a_fault_zero, is_fault, fault_ok)

	`FLTW_ASSERT_IMP(a_map_shape, is_map, map_ok)

endmodule

bind four_level_page_table_walker_unit fltw_checker u_fltw_checker (.*);
